@@ src/ncola_pkg.sv @@
// ----------------------------------------------------------------------------
// ncola_pkg
// Shared constants, register indexes, state codes and the window generator
// for the neural cycle overlap-add synthesizer.
// ----------------------------------------------------------------------------
package ncola_pkg;

  // Network shape and default sizes
  localparam int NET_INPUTS       = 3;
  localparam int INP_W            = 2;
  localparam int HIDDEN_UNITS_DEF = 64;
  localparam int CYCLE_LEN_DEF    = 200;
  localparam int WEIGHT_BITS_DEF  = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SELECT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECODER_READY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LATENT_VALUE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOW_POSITION  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOW_PRESSURE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_GAIN   = 3'd5;

  // Leak factor 0.99 in Q16
  localparam logic [16:0] LEAK_Q16 = 17'd64881;

  // Window generator constants (Q30 / Q29)
  localparam logic [63:0] Q30_ONE    = 64'd1073741824;
  localparam logic [63:0] TWO_PI_Q29 = 64'd3373259426;
  localparam logic [63:0] C054_Q30   = 64'd579820585;
  localparam logic [63:0] C046_Q30   = 64'd493921239;

  typedef enum logic [12:0] {
    ST_IDLE       = 13'b0000000000001,
    ST_DEC_HID    = 13'b0000000000010,
    ST_DEC_HDRAIN = 13'b0000000000100,
    ST_DEC_OUT    = 13'b0000000001000,
    ST_DEC_ODRAIN = 13'b0000000010000,
    ST_RD0        = 13'b0000000100000,
    ST_RD1        = 13'b0000001000000,
    ST_RD2        = 13'b0000010000000,
    ST_LEAK       = 13'b0000100000000,
    ST_INTEG      = 13'b0001000000000,
    ST_SCALE      = 13'b0010000000000,
    ST_SAT        = 13'b0100000000000,
    ST_DONE       = 13'b1000000000000
  } state_t;

  // Hamming window value in Q1.15 for a phase p = i * 2^32 / (N - 1).
  // Cosine from a Taylor series in nested form, folded to the first quadrant.
  function automatic logic [15:0] hamming_q15(input logic [63:0] p_in);
    logic [63:0] p;
    logic [63:0] theta;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] m;
    logic [63:0] prod;
    logic [63:0] w;
    logic        neg;
    int          d;
    p   = p_in;
    neg = 1'b0;
    if (p > 64'd2147483648) p = 64'h1_0000_0000 - p;
    if (p > 64'd1073741824) begin
      p   = 64'd2147483648 - p;
      neg = 1'b1;
    end
    theta = (p * TWO_PI_Q29) >> 31;
    x2    = (theta * theta) >> 30;
    t     = Q30_ONE;
    for (d = 0; d < 6; d++) begin
      m = (x2 * t) >> 30;
      case (d)
        0:       m = m / 64'd132;
        1:       m = m / 64'd90;
        2:       m = m / 64'd56;
        3:       m = m / 64'd30;
        4:       m = m / 64'd12;
        default: m = m / 64'd2;
      endcase
      t = (m > Q30_ONE) ? 64'd0 : Q30_ONE - m;
    end
    prod = (t * C046_Q30) >> 30;
    w    = neg ? C054_Q30 + prod : C054_Q30 - prod;
    return 16'((w + 64'd16384) >> 15);
  endfunction

endpackage

@@ src/ncola_ram.sv @@
// ----------------------------------------------------------------------------
// ncola_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ncola_ram #(
  parameter int WIDTH = ncola_pkg::WEIGHT_BITS_DEF,
  parameter int DEPTH = ncola_pkg::HIDDEN_UNITS_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ src/neural_cycle_ola_synth.sv @@
// ----------------------------------------------------------------------------
// neural_cycle_ola_synth
// Single-cycle overlap-add synthesizer: a small ReLU network decodes one
// waveform cycle into one of two buffers; ticks read both windowed buffers
// half a cycle apart into a leaky integrator and scale to one sample.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  in      | sink      | in_valid/in_stall  | mode, weight_addr, weight_value
//  out     | source    | out_valid/out_stall| sample
//  cfg     | sink      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  A weight item is written in the cycle it is accepted and gives no result.
//  A tick without decoding passes RD0, RD1, RD2, LEAK, INTEG, SCALE, SAT and
//  DONE to the output register; the next item is taken in the cycle after, in IDLE.
//  A tick that decodes first passes DEC_HID, DEC_HDRAIN, DEC_OUT and
//  DEC_ODRAIN, one multiply-accumulate per cycle as set by the single read
//  port of the weight memory; two of every C ticks decode if decoder_ready
//  is set, and the other ticks go straight to RD0 (to DONE if output_select).
//  Synchronous active-high reset restores control, config and integrator;
//  both waveform buffers read as zero until first decoded, no clearing pass.
//  The output register holds a result while out_stall is high; a new item is
//  taken meanwhile, and the block waits at its end until the register frees.
// ----------------------------------------------------------------------------
module neural_cycle_ola_synth #(
  parameter int HIDDEN_UNITS = ncola_pkg::HIDDEN_UNITS_DEF,
  parameter int CYCLE_LEN    = ncola_pkg::CYCLE_LEN_DEF,
  parameter int WEIGHT_BITS  = ncola_pkg::WEIGHT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // item input
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             mode,
  input  logic [13:0]                      weight_addr,
  input  logic signed [15:0]               weight_value,
  // result output
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [15:0]               sample,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ncola_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ncola_pkg::CFG_DATA_W-1:0] cfg_data
);

  // --------------------------------------------------------------------------
  // Memory map and widths
  // --------------------------------------------------------------------------
  localparam int NI        = ncola_pkg::NET_INPUTS;
  localparam int W3_BASE   = 0;
  localparam int W4_BASE   = W3_BASE + NI * HIDDEN_UNITS;
  localparam int B3_BASE   = W4_BASE + HIDDEN_UNITS * CYCLE_LEN;
  localparam int B4_BASE   = B3_BASE + HIDDEN_UNITS;
  localparam int MEM_DEPTH = B4_BASE + CYCLE_LEN;
  localparam int HALF      = (CYCLE_LEN - 1) / 2;

  localparam int WA_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int HID_AW   = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
  localparam int CIDX_W   = $clog2(CYCLE_LEN);
  localparam int CB_DEPTH = 2 * (2 ** CIDX_W);
  localparam int CB_AW    = CIDX_W + 1;
  localparam int PI_W     = $clog2(CYCLE_LEN + 1);
  localparam int UNIT_W   = $clog2((HIDDEN_UNITS > CYCLE_LEN) ? HIDDEN_UNITS : CYCLE_LEN);
  localparam int TERM_W   = $clog2(((HIDDEN_UNITS > NI) ? HIDDEN_UNITS : NI) + 1);

  localparam logic signed [31:0] WLIM = 32'((64'sd1 <<< (WEIGHT_BITS - 1)) - 1);
  localparam logic signed [31:0] WMIN = -WLIM - 32'sd1;

  typedef struct packed {
    logic              valid;
    logic              out_ph;
    logic              first;
    logic              last;
    logic [TERM_W-1:0] term;
    logic [UNIT_W-1:0] unit;
  } pipe_t;

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) return 16'sh7FFF;
    if (v < -64'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  ncola_pkg::state_t state, state_next;

  logic               output_select;
  logic               decoder_ready;
  logic signed [15:0] latent_value;
  logic [6:0]         bow_position;
  logic [6:0]         bow_pressure;
  logic [15:0]        volume_gain;

  logic [PI_W-1:0]    play_index;
  logic signed [31:0] integ;
  logic [1:0]         buf_valid;
  logic               dec_buf;
  logic [CIDX_W-1:0]  tick_j;
  logic [CIDX_W-1:0]  tick_k;

  // decode issue counters
  logic [UNIT_W-1:0]  iss_j;
  logic [TERM_W-1:0]  iss_t;
  logic [WA_W-1:0]    iss_addr;

  // MAC pipeline
  pipe_t                        s1, s2, s3;
  logic signed [31+WEIGHT_BITS:0] prod;
  logic signed [63:0]           acc;

  // tick datapath
  logic [15:0]        win_q;
  logic signed [48:0] d1, d2;
  logic signed [49:0] dsum;
  logic signed [48:0] leak_prod;
  logic signed [48:0] scaled;
  logic signed [15:0] res;

  // memory ports
  logic                   wt_we;
  logic [WEIGHT_BITS-1:0] wt_wdata;
  logic [WEIGHT_BITS-1:0] wt_rdata;
  logic                   hid_we;
  logic [31:0]            hid_wdata;
  logic [31:0]            hid_rdata;
  logic                   cb_we;
  logic [31:0]            cb_wdata;
  logic [CB_AW-1:0]       cb_raddr;
  logic [31:0]            cb_rdata;

  // --------------------------------------------------------------------------
  // Window table, built at elaboration
  // --------------------------------------------------------------------------
  logic [15:0] win_rom [CYCLE_LEN];

  for (genvar gi = 0; gi < CYCLE_LEN; gi++) begin : g_win
    localparam logic [63:0] PH = (64'(gi) << 32) / 64'(CYCLE_LEN - 1);
    assign win_rom[gi] = ncola_pkg::hamming_q15(PH);
  end

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  logic in_acc;
  logic out_free;

  assign in_stall  = (state != ncola_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !(out_valid && out_stall);

  // --------------------------------------------------------------------------
  // Play position for an accepted tick: wrap the first read index, place the
  // second HALF ahead of it, and decide which buffer (if any) to refresh.
  // --------------------------------------------------------------------------
  logic              pi_wrap;
  logic [CIDX_W-1:0] j0;
  logic [CIDX_W:0]   ksum;
  logic [CIDX_W-1:0] k0;
  logic              k_dec;
  logic              need_dec;

  always_comb begin
    pi_wrap  = (play_index >= PI_W'(CYCLE_LEN));
    j0       = pi_wrap ? '0 : CIDX_W'(play_index);
    ksum     = {1'b0, j0} + (CIDX_W + 1)'(HALF);
    k0       = (ksum >= (CIDX_W + 1)'(CYCLE_LEN)) ?
               CIDX_W'(ksum - (CIDX_W + 1)'(CYCLE_LEN)) : ksum[CIDX_W-1:0];
    k_dec    = (ksum == (CIDX_W + 1)'(CYCLE_LEN));
    need_dec = pi_wrap || k_dec;
  end

  // --------------------------------------------------------------------------
  // Decode issue: one weight read per cycle. Term 0 is the bias, terms 1..n
  // walk a column of the weight matrix with a fixed stride.
  // --------------------------------------------------------------------------
  logic              is_out;
  logic              term_last;
  logic              unit_last;
  logic [WA_W-1:0]   stride;
  logic [WA_W-1:0]   wbase;
  logic [WA_W-1:0]   bbase;
  logic [WA_W-1:0]   addr_next;
  logic              pipe_empty;

  always_comb begin
    is_out    = (state == ncola_pkg::ST_DEC_OUT);
    term_last = is_out ? (iss_t == TERM_W'(HIDDEN_UNITS)) : (iss_t == TERM_W'(NI));
    unit_last = is_out ? (iss_j == UNIT_W'(CYCLE_LEN - 1)) :
                         (iss_j == UNIT_W'(HIDDEN_UNITS - 1));
    stride    = is_out ? WA_W'(CYCLE_LEN) : WA_W'(HIDDEN_UNITS);
    wbase     = is_out ? WA_W'(W4_BASE) : WA_W'(W3_BASE);
    bbase     = is_out ? WA_W'(B4_BASE) : WA_W'(B3_BASE);
    if (term_last) begin
      addr_next = bbase + WA_W'(iss_j) + WA_W'(1);
    end else if (iss_t == '0) begin
      addr_next = wbase + WA_W'(iss_j);
    end else begin
      addr_next = iss_addr + stride;
    end
    pipe_empty = !s1.valid && !s2.valid && !s3.valid;
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ncola_pkg::ST_IDLE: begin
        if (in_acc && mode) begin
          if (output_select) state_next = ncola_pkg::ST_DONE;
          else if (need_dec && decoder_ready) state_next = ncola_pkg::ST_DEC_HID;
          else state_next = ncola_pkg::ST_RD0;
        end
      end
      ncola_pkg::ST_DEC_HID: begin
        if (term_last && unit_last) state_next = ncola_pkg::ST_DEC_HDRAIN;
      end
      ncola_pkg::ST_DEC_HDRAIN: begin
        if (pipe_empty) state_next = ncola_pkg::ST_DEC_OUT;
      end
      ncola_pkg::ST_DEC_OUT: begin
        if (term_last && unit_last) state_next = ncola_pkg::ST_DEC_ODRAIN;
      end
      ncola_pkg::ST_DEC_ODRAIN: begin
        if (pipe_empty) state_next = ncola_pkg::ST_RD0;
      end
      ncola_pkg::ST_RD0:   state_next = ncola_pkg::ST_RD1;
      ncola_pkg::ST_RD1:   state_next = ncola_pkg::ST_RD2;
      ncola_pkg::ST_RD2:   state_next = ncola_pkg::ST_LEAK;
      ncola_pkg::ST_LEAK:  state_next = ncola_pkg::ST_INTEG;
      ncola_pkg::ST_INTEG: state_next = ncola_pkg::ST_SCALE;
      ncola_pkg::ST_SCALE: state_next = ncola_pkg::ST_SAT;
      ncola_pkg::ST_SAT:   state_next = ncola_pkg::ST_DONE;
      ncola_pkg::ST_DONE: begin
        if (out_free) state_next = ncola_pkg::ST_IDLE;
      end
      default: state_next = ncola_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Weight write: saturate to the stored width, drop addresses past the end
  // --------------------------------------------------------------------------
  logic signed [31:0] wv;
  logic signed [31:0] wv_sat;

  always_comb begin
    wv = 32'(weight_value);
    if (wv > WLIM) wv_sat = WLIM;
    else if (wv < WMIN) wv_sat = WMIN;
    else wv_sat = wv;
    wt_wdata = wv_sat[WEIGHT_BITS-1:0];
    wt_we    = in_acc && !mode && (32'(weight_addr) < 32'(MEM_DEPTH));
  end

  // --------------------------------------------------------------------------
  // MAC operand select (stage 1, weight data just out of memory)
  // --------------------------------------------------------------------------
  logic signed [31:0] inp [NI];
  logic signed [31:0] opnd;

  always_comb begin
    inp[0] = 32'(latent_value);
    inp[1] = 32'($signed({1'b0, bow_position}) - 9'sd32) <<< 10;
    inp[2] = 32'($signed({1'b0, bow_pressure}) - 9'sd64) <<< 9;
    if (s1.first) opnd = 32'sd32768;
    else if (s1.out_ph) opnd = $signed(hid_rdata);
    else opnd = inp[ncola_pkg::INP_W'(s1.term - TERM_W'(1))];
  end

  // --------------------------------------------------------------------------
  // Writeback (stage 3): round half up, ReLU for the hidden layer, saturate
  // --------------------------------------------------------------------------
  logic signed [63:0] acc_rnd;

  always_comb begin
    acc_rnd   = (acc + 64'sd2048) >>> 12;
    hid_wdata = (acc < 0) ? 32'd0 : sat32(acc_rnd);
    cb_wdata  = sat32(acc_rnd);
    hid_we    = s3.valid && s3.last && !s3.out_ph;
    cb_we     = s3.valid && s3.last && s3.out_ph;
    cb_raddr  = (state == ncola_pkg::ST_RD0) ? {1'b0, tick_j} : {1'b1, tick_k};
  end

  // --------------------------------------------------------------------------
  // Tick arithmetic
  // --------------------------------------------------------------------------
  logic signed [31:0] cb_val;
  logic [1:0]         rd_buf_ok;
  logic signed [63:0] integ_acc;
  logic signed [63:0] out_rnd;

  always_comb begin
    // buffer 0 data arrives in RD1, buffer 1 data in RD2
    rd_buf_ok = buf_valid;
    if (state == ncola_pkg::ST_RD1) cb_val = rd_buf_ok[0] ? $signed(cb_rdata) : 32'sd0;
    else cb_val = rd_buf_ok[1] ? $signed(cb_rdata) : 32'sd0;
    integ_acc = 64'(leak_prod) + (64'(dsum) <<< 1) + 64'sd32768;
    out_rnd   = (64'(scaled) + 64'sd16384) >>> 15;
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ncola_pkg::ST_IDLE;
      output_select <= 1'b0;
      decoder_ready <= 1'b0;
      latent_value  <= 16'sd16384;
      bow_position  <= 7'd32;
      bow_pressure  <= 7'd64;
      volume_gain   <= 16'd16384;
      play_index    <= '0;
      integ         <= '0;
      buf_valid     <= '0;
      out_valid     <= 1'b0;
      s1            <= '0;
      s2            <= '0;
      s3            <= '0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ncola_pkg::REG_OUTPUT_SELECT: output_select <= cfg_data[0];
          ncola_pkg::REG_DECODER_READY: decoder_ready <= cfg_data[0];
          ncola_pkg::REG_LATENT_VALUE:  latent_value  <= $signed(cfg_data);
          ncola_pkg::REG_BOW_POSITION:  bow_position  <= cfg_data[6:0];
          ncola_pkg::REG_BOW_PRESSURE:  bow_pressure  <= cfg_data[6:0];
          ncola_pkg::REG_VOLUME_GAIN:   volume_gain   <= cfg_data;
          default: ;
        endcase
      end

      // advance the MAC pipeline
      s1.valid  <= (state == ncola_pkg::ST_DEC_HID) || is_out;
      s1.out_ph <= is_out;
      s1.first  <= (iss_t == '0);
      s1.last   <= term_last;
      s1.term   <= iss_t;
      s1.unit   <= iss_j;
      s2        <= s1;
      s3        <= s2;

      // mark the buffer live once fully decoded
      if (state == ncola_pkg::ST_DEC_ODRAIN && pipe_empty) buf_valid[dec_buf] <= 1'b1;

      if (state == ncola_pkg::ST_INTEG) begin
        integ      <= sat32(integ_acc >>> 16);
        play_index <= PI_W'(tick_j) + PI_W'(1);
      end

      // load the output register, or drop a taken result
      if (state == ncola_pkg::ST_DONE && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state == ncola_pkg::ST_IDLE && in_acc && mode) begin
      tick_j  <= j0;
      tick_k  <= k0;
      dec_buf <= !pi_wrap;
      res     <= '0;
    end

    // issue counters: start each layer at its bias base
    if (state == ncola_pkg::ST_IDLE) begin
      iss_j    <= '0;
      iss_t    <= '0;
      iss_addr <= WA_W'(B3_BASE);
    end else if (state == ncola_pkg::ST_DEC_HDRAIN) begin
      iss_j    <= '0;
      iss_t    <= '0;
      iss_addr <= WA_W'(B4_BASE);
    end else if (state == ncola_pkg::ST_DEC_HID || is_out) begin
      iss_addr <= addr_next;
      if (term_last) begin
        iss_t <= '0;
        iss_j <= iss_j + UNIT_W'(1);
      end else begin
        iss_t <= iss_t + TERM_W'(1);
      end
    end

    prod <= opnd * $signed(wt_rdata);
    if (s2.valid) acc <= s2.first ? 64'(prod) : acc + 64'(prod);

    case (state)
      ncola_pkg::ST_RD0: win_q <= win_rom[tick_j];
      ncola_pkg::ST_RD1: begin
        d1    <= $signed({1'b0, win_q}) * cb_val;
        win_q <= win_rom[tick_k];
      end
      ncola_pkg::ST_RD2: d2 <= $signed({1'b0, win_q}) * cb_val;
      ncola_pkg::ST_LEAK: begin
        leak_prod <= integ * $signed(ncola_pkg::LEAK_Q16);
        dsum      <= 50'(d1) + 50'(d2);
      end
      ncola_pkg::ST_SCALE: scaled <= integ * $signed({1'b0, volume_gain});
      ncola_pkg::ST_SAT:   res <= sat16(out_rnd);
      default: ;
    endcase

    if (state == ncola_pkg::ST_DONE && out_free) sample <= res;
  end

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  ncola_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MEM_DEPTH)) u_wt_ram (
    .clk   (clk),
    .we    (wt_we),
    .waddr (WA_W'(weight_addr)),
    .wdata (wt_wdata),
    .raddr (iss_addr),
    .rdata (wt_rdata)
  );

  ncola_ram #(.WIDTH(32), .DEPTH(HIDDEN_UNITS)) u_hid_ram (
    .clk   (clk),
    .we    (hid_we),
    .waddr (HID_AW'(s3.unit)),
    .wdata (hid_wdata),
    .raddr (HID_AW'(iss_t - TERM_W'(1))),
    .rdata (hid_rdata)
  );

  ncola_ram #(.WIDTH(32), .DEPTH(CB_DEPTH)) u_cb_ram (
    .clk   (clk),
    .we    (cb_we),
    .waddr ({dec_buf, CIDX_W'(s3.unit)}),
    .wdata (cb_wdata),
    .raddr (cb_raddr),
    .rdata (cb_rdata)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_hid_wr_window: assert property (@(posedge clk) disable iff (rst)
    hid_we |-> (state == ncola_pkg::ST_DEC_HID || state == ncola_pkg::ST_DEC_HDRAIN))
    else $error("hidden write outside hidden layer pass");

  a_cb_wr_window: assert property (@(posedge clk) disable iff (rst)
    cb_we |-> (state == ncola_pkg::ST_DEC_OUT || state == ncola_pkg::ST_DEC_ODRAIN))
    else $error("cycle buffer write outside output layer pass");

  a_play_range: assert property (@(posedge clk) disable iff (rst)
    play_index <= PI_W'(CYCLE_LEN))
    else $error("play index past cycle length");

  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ncola_pkg::ST_RD0) |-> pipe_empty)
    else $error("tick read with decode still in flight");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ncola_pkg::ST_DONE && out_free) |=> out_valid)
    else $error("result not presented");

endmodule
